// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== src/blst_pkg.sv =====
// ----------------------------------------------------------------------------
// blst_pkg
// shared types and codes of the bounded lifo stack
// ----------------------------------------------------------------------------
package blst_pkg;

  localparam int CAP_W = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_PEEK = 2'd2;
  localparam logic [1:0] CMD_DISP = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef logic [1:0] cell_op_t;

  localparam cell_op_t OP_HOLD = 2'd0;
  localparam cell_op_t OP_PUSH = 2'd1;
  localparam cell_op_t OP_POP  = 2'd2;
  localparam cell_op_t OP_ROT  = 2'd3;

  typedef struct packed {
    cell_op_t op;
  } chain_ctl_t;

endpackage

// ===== src/blst_ifs.sv =====
// ----------------------------------------------------------------------------
// blst_ifs
// request, response and configuration channels of the stack
// ----------------------------------------------------------------------------
interface blst_req_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   cmd;
  logic signed [DATA_WIDTH-1:0] push_value;

  modport source (output valid, output cmd, output push_value, input ready);
  modport sink (input valid, input cmd, input push_value, output ready);
endinterface

interface blst_rsp_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic signed [DATA_WIDTH-1:0] data_out;
  logic                         is_empty;
  logic                         is_full;
  logic                         last;

  modport source (output valid, output status, output data_out, output is_empty,
                  output is_full, output last, input ready);
  modport sink (input valid, input status, input data_out, input is_empty,
                input is_full, input last, output ready);
endinterface

interface blst_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] capacity;

  modport source (output valid, output capacity, input ready);
  modport sink (input valid, input capacity, output ready);
endinterface

// ===== src/blst_cell.sv =====
// ----------------------------------------------------------------------------
// blst_cell
// one stack slot, shifts toward its neighbors on push, pop and rotate
// ----------------------------------------------------------------------------
module blst_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  blst_pkg::chain_ctl_t  ctl,
  input  logic                  is_tail,
  input  logic [DATA_WIDTH-1:0] up_in,
  input  logic [DATA_WIDTH-1:0] down_in,
  input  logic [DATA_WIDTH-1:0] top_in,
  output logic [DATA_WIDTH-1:0] word
);
  import blst_pkg::*;

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_PUSH: word <= up_in;
      OP_POP:  word <= down_in;
      OP_ROT:  word <= is_tail ? top_in : down_in;
      default: word <= word;
    endcase
  end

endmodule

// ===== src/blst_ctrl.sv =====
// ----------------------------------------------------------------------------
// blst_ctrl
// command decode, entry count, capacity register and response register
// ----------------------------------------------------------------------------
module blst_ctrl #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32,
  parameter int IDX_W      = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  blst_req_if.sink              req,
  blst_rsp_if.source            rsp,
  blst_cfg_if.sink              cfg,
  input  logic [DATA_WIDTH-1:0] top_word,
  output blst_pkg::chain_ctl_t  ctl,
  output logic [IDX_W-1:0]      tail
);
  import blst_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DISP = 1'b1;

  logic                  state, state_next;
  logic [CNT_W-1:0]      count, count_next;
  logic [CNT_W-1:0]      rem, rem_next;
  logic [CAP_W-1:0]      capacity;
  logic                  ov;
  logic [1:0]            status;
  logic [DATA_WIDTH-1:0] data;
  logic                  empty_f, full_f, last_f;

  logic                  load_ok, accept, load;
  logic [1:0]            status_next;
  logic [DATA_WIDTH-1:0] data_next;
  logic                  last_next;
  logic [CMP_W-1:0]      cap_ext, eff_cap;
  logic                  full_now, empty_now;
  logic [CNT_W-1:0]      cnt_m1;

  assign load_ok   = !ov || rsp.ready;
  assign req.ready = (state == ST_IDLE) && load_ok;
  assign accept    = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  always_comb begin
    cap_ext = CMP_W'(capacity);
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(DEPTH)) begin
      eff_cap = CMP_W'(DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign full_now  = CMP_W'(count) >= eff_cap;
  assign empty_now = (count == '0);
  assign cnt_m1    = count - CNT_W'(1);
  assign tail      = cnt_m1[IDX_W-1:0];

  always_comb begin
    state_next  = state;
    count_next  = count;
    rem_next    = rem;
    load        = 1'b0;
    status_next = STATUS_OK;
    data_next   = '0;
    last_next   = 1'b1;
    ctl.op      = OP_HOLD;
    if (accept) begin
      load = 1'b1;
      case (req.cmd)
        CMD_PUSH: begin
          if (full_now) begin
            status_next = STATUS_FULL;
          end else begin
            ctl.op     = OP_PUSH;
            count_next = count + CNT_W'(1);
          end
        end
        CMD_POP: begin
          if (empty_now) begin
            status_next = STATUS_EMPTY;
          end else begin
            ctl.op     = OP_POP;
            data_next  = top_word;
            count_next = cnt_m1;
          end
        end
        CMD_PEEK: begin
          if (empty_now) begin
            status_next = STATUS_EMPTY;
          end else begin
            data_next = top_word;
          end
        end
        default: begin
          if (empty_now) begin
            status_next = STATUS_EMPTY;
          end else begin
            ctl.op    = OP_ROT;
            data_next = top_word;
            last_next = (count == CNT_W'(1));
            if (count != CNT_W'(1)) begin
              state_next = ST_DISP;
              rem_next   = cnt_m1;
            end
          end
        end
      endcase
    end else if (state == ST_DISP && load_ok) begin
      load      = 1'b1;
      ctl.op    = OP_ROT;
      data_next = top_word;
      last_next = (rem == CNT_W'(1));
      rem_next  = rem - CNT_W'(1);
      if (rem == CNT_W'(1)) begin
        state_next = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      rem      <= '0;
      ov       <= 1'b0;
      capacity <= CAP_RESET;
    end else begin
      state <= state_next;
      count <= count_next;
      rem   <= rem_next;
      if (load) begin
        ov <= 1'b1;
      end else if (rsp.ready) begin
        ov <= 1'b0;
      end
      if (cfg.valid) begin
        capacity <= cfg.capacity;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status  <= status_next;
      data    <= data_next;
      last_f  <= last_next;
      empty_f <= (count_next == '0);
      full_f  <= CMP_W'(count_next) >= eff_cap;
    end
  end

  assign rsp.valid    = ov;
  assign rsp.status   = status;
  assign rsp.data_out = $signed(data);
  assign rsp.is_empty = empty_f;
  assign rsp.is_full  = full_f;
  assign rsp.last     = last_f;

endmodule

// ===== src/bounded_lifo_stack_top.sv =====
// ----------------------------------------------------------------------------
// bounded_lifo_stack_top
// bounded lifo stack of signed words built as a row of shifting cells
// ----------------------------------------------------------------------------
// usage:
//   req carries one command per request: push, pop, peek or display.
//   rsp returns results with status, data word, empty and full flags and
//   a last mark on the final result of a request.
//   user writes capacity register only when block is idle; unenforced.
// timing:
//   push, pop and peek give one result in the cycle after the request.
//   display gives one result per stored word, top first, one per cycle
//   while rsp is ready; the cell row rotates once per result and is back
//   in order at the end. a new request is taken once the prior one has
//   issued its last result, so push, pop and peek take one request per
//   cycle while rsp is ready; a display holds off requests to its end.
// reset:
//   rst clears the entry count and sets capacity to 64; cell words are
//   undefined until pushed.
// stall:
//   rsp holds its result while ready is low; req.ready drops meanwhile.
// ----------------------------------------------------------------------------
module bounded_lifo_stack_top #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input logic        clk,
  input logic        rst,
  blst_req_if.sink   req,
  blst_rsp_if.source rsp,
  blst_cfg_if.sink   cfg
);
  import blst_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);

  logic [DATA_WIDTH-1:0] word [DEPTH];
  chain_ctl_t            ctl;
  logic [IDX_W-1:0]      tail;
  logic [DATA_WIDTH-1:0] push_word;

  assign push_word = DATA_WIDTH'(req.push_value);

  blst_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .cfg      (cfg),
    .top_word (word[0]),
    .ctl      (ctl),
    .tail     (tail)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] up_in, down_in;
    if (i == 0) begin : g_first
      assign up_in = push_word;
    end else begin : g_mid
      assign up_in = word[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign down_in = '0;
    end else begin : g_inner
      assign down_in = word[i+1];
    end
    blst_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .is_tail (tail == IDX_W'(i)),
      .up_in   (up_in),
      .down_in (down_in),
      .top_in  (word[0]),
      .word    (word[i])
    );
  end

endmodule

// ===== src/blst_checker.sv =====
// ----------------------------------------------------------------------------
// blst_checker
// port-level assertions for the bounded lifo stack
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module blst_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  req_ready,
  input logic                  rsp_valid,
  input logic                  rsp_ready,
  input logic [1:0]            status,
  input logic [DATA_WIDTH-1:0] data_out,
  input logic                  is_empty,
  input logic                  is_full,
  input logic                  last
);
  import blst_pkg::*;

  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(data_out) && $stable(status) && $stable(last))
  `ASSERT_IMPLY(a_no_req_on_stall, clk, rst, rsp_valid && !rsp_ready, !req_ready)
  `ASSERT_IMPLY(a_reject_single, clk, rst, rsp_valid && status != STATUS_OK, last && data_out == '0)
  `ASSERT_IMPLY(a_empty_single, clk, rst, rsp_valid && is_empty, last)
  `ASSERT_IMPLY(a_full_flags, clk, rst, rsp_valid && status == STATUS_FULL, is_full && !is_empty)

endmodule

bind bounded_lifo_stack_top blst_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_blst_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .status    (rsp.status),
  .data_out  (rsp.data_out),
  .is_empty  (rsp.is_empty),
  .is_full   (rsp.is_full),
  .last      (rsp.last)
);
